@@ rtl/core/smae_pkg.sv @@
`timescale 1ns / 1ps

package smae_pkg;

  localparam int MAX_DIM   = 8;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD       = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB       = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL       = 3'd4;
  localparam logic [OP_W-1:0] OP_TRANSPOSE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;

  typedef logic [DIM_W-1:0] dim_t;

  typedef struct packed {
    dim_t rows_a;
    dim_t cols_a;
    dim_t rows_b;
    dim_t cols_b;
  } dims_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MAC,
    ALU_PASS
  } alu_op_t;

  typedef struct packed {
    logic    en;
    logic    first;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MISM,
    ST_READ,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // zero reads as one, anything above the store size as the store size
  function automatic dim_t clamp_dim(dim_t v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [IDX_W-1:0] r,
                                                  logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

@@ rtl/core/smae_ram.sv @@
`timescale 1ns / 1ps

module smae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/smae_alu.sv @@
`timescale 1ns / 1ps

module smae_alu (
  input  logic                          clk,
  input  smae_pkg::alu_ctl_t            ctl,
  input  logic [smae_pkg::DATA_W-1:0]   a,
  input  logic [smae_pkg::DATA_W-1:0]   b,
  output logic [smae_pkg::DATA_W-1:0]   acc
);

  logic [smae_pkg::DATA_W-1:0]   acc_r;
  logic [smae_pkg::DATA_W-1:0]   acc_nxt;
  logic [smae_pkg::DATA_W-1:0]   base;
  logic [2*smae_pkg::DATA_W-1:0] prod;

  always_comb begin
    base = ctl.first ? '0 : acc_r;
    prod = a * b;
    case (ctl.op)
      smae_pkg::ALU_ADD:  acc_nxt = a + b;
      smae_pkg::ALU_SUB:  acc_nxt = a - b;
      smae_pkg::ALU_MAC:  acc_nxt = base + prod[smae_pkg::DATA_W-1:0];
      smae_pkg::ALU_PASS: acc_nxt = a;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/smae_seq.sv @@
`timescale 1ns / 1ps

module smae_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smae_pkg::OP_W-1:0]         in_operation,
  input  smae_pkg::dims_t                   dims,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_status,
  output logic [smae_pkg::IDX_W-1:0]        out_row,
  output logic [smae_pkg::IDX_W-1:0]        out_col,
  output logic [smae_pkg::DATA_W-1:0]       out_value,
  output logic                              out_last,
  output smae_pkg::alu_ctl_t                alu_ctl,
  input  logic [smae_pkg::DATA_W-1:0]       acc,
  output logic [smae_pkg::ADDR_W-1:0]       addr_a,
  output logic [smae_pkg::ADDR_W-1:0]       addr_b
);

  smae_pkg::state_t state_r, state_nxt;
  logic [smae_pkg::OP_W-1:0]  op_r, op_nxt;
  smae_pkg::dim_t             nr_r, nr_nxt, nc_r, nc_nxt, nk_r, nk_nxt;
  logic [smae_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r, out_status_nxt;
  logic [smae_pkg::IDX_W-1:0]  out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [smae_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                        out_last_r, out_last_nxt;

  smae_pkg::dim_t ra, ca, rb, cb;
  logic           out_free, last_i, last_j, last_k;

  always_comb begin
    ra = smae_pkg::clamp_dim(dims.rows_a);
    ca = smae_pkg::clamp_dim(dims.cols_a);
    rb = smae_pkg::clamp_dim(dims.rows_b);
    cb = smae_pkg::clamp_dim(dims.cols_b);

    out_free = !out_valid_r || out_ready;
    last_i   = ({1'b0, i_r} + smae_pkg::DIM_W'(1)) == nr_r;
    last_j   = ({1'b0, j_r} + smae_pkg::DIM_W'(1)) == nc_r;
    last_k   = ({1'b0, k_r} + smae_pkg::DIM_W'(1)) == nk_r;

    state_nxt      = state_r;
    op_nxt         = op_r;
    nr_nxt         = nr_r;
    nc_nxt         = nc_r;
    nk_nxt         = nk_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    alu_ctl.en     = 1'b0;
    alu_ctl.first  = (k_r == '0);
    in_ready       = (state_r == smae_pkg::ST_IDLE);

    case (op_r)
      smae_pkg::OP_ADD: alu_ctl.op = smae_pkg::ALU_ADD;
      smae_pkg::OP_SUB: alu_ctl.op = smae_pkg::ALU_SUB;
      smae_pkg::OP_MUL: alu_ctl.op = smae_pkg::ALU_MAC;
      default:          alu_ctl.op = smae_pkg::ALU_PASS;
    endcase

    case (op_r)
      smae_pkg::OP_MUL: begin
        addr_a = smae_pkg::cell_addr(i_r, k_r);
        addr_b = smae_pkg::cell_addr(k_r, j_r);
      end
      smae_pkg::OP_TRANSPOSE: begin
        addr_a = smae_pkg::cell_addr(j_r, i_r);
        addr_b = smae_pkg::cell_addr(i_r, j_r);
      end
      default: begin
        addr_a = smae_pkg::cell_addr(i_r, j_r);
        addr_b = smae_pkg::cell_addr(i_r, j_r);
      end
    endcase

    unique case (state_r)
      smae_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          i_nxt  = '0;
          j_nxt  = '0;
          k_nxt  = '0;
          unique case (in_operation) inside
            smae_pkg::OP_ADD, smae_pkg::OP_SUB: begin
              nr_nxt    = ra;
              nc_nxt    = ca;
              nk_nxt    = smae_pkg::DIM_W'(1);
              state_nxt = (ra != rb || ca != cb) ? smae_pkg::ST_MISM
                                                  : smae_pkg::ST_READ;
            end
            smae_pkg::OP_MUL: begin
              nr_nxt    = ra;
              nc_nxt    = cb;
              nk_nxt    = ca;
              state_nxt = (ca != rb) ? smae_pkg::ST_MISM : smae_pkg::ST_READ;
            end
            smae_pkg::OP_TRANSPOSE: begin
              nr_nxt    = ca;
              nc_nxt    = ra;
              nk_nxt    = smae_pkg::DIM_W'(1);
              state_nxt = smae_pkg::ST_READ;
            end
            default: ;  // loads and unused codes stay idle
          endcase
        end
      end
      smae_pkg::ST_MISM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          out_row_nxt    = '0;
          out_col_nxt    = '0;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = smae_pkg::ST_IDLE;
        end
      end
      smae_pkg::ST_READ: begin
        state_nxt = smae_pkg::ST_EXEC;
      end
      smae_pkg::ST_EXEC: begin
        alu_ctl.en = 1'b1;
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = smae_pkg::ST_EMIT;
        end else begin
          k_nxt     = k_r + smae_pkg::IDX_W'(1);
          state_nxt = smae_pkg::ST_READ;
        end
      end
      smae_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_row_nxt    = i_r;
          out_col_nxt    = j_r;
          out_value_nxt  = acc;
          out_last_nxt   = last_i && last_j;
          state_nxt      = smae_pkg::ST_READ;
          if (last_j) begin
            j_nxt = '0;
            if (last_i) begin
              state_nxt = smae_pkg::ST_IDLE;
            end else begin
              i_nxt = i_r + smae_pkg::IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + smae_pkg::IDX_W'(1);
          end
        end
      end
      default: state_nxt = smae_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smae_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    nr_r         <= nr_nxt;
    nc_r         <= nc_nxt;
    nk_r         <= nk_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

@@ rtl/core/small_matrix_arith_engine_unit.sv @@
`timescale 1ns / 1ps
// channel | handshake            | word
// in_     | in_valid / in_ready  | operation, row_index, col_index, element_value
// out_    | out_valid / out_ready| status, out_row, out_col, out_value, last
// cfg_    | cfg_valid / cfg_ready| cfg_index, cfg_data (rows_a, cols_a, rows_b, cols_b)
//
// Loads and unused codes leave the engine idle. Each result element takes a read and
// an execute step per inner index (inner dimension for multiply, else 1) on the shared
// add/multiply-accumulate unit, the read step set by the one-port registered read of
// each store, then an emit step. A size mismatch gives its word from the mismatch step.
// Reset clears control and the per-entry valid bits; a never-loaded entry reads 0.
// A stalled output holds the sequencer at emit or mismatch; in_ready is high when idle.

module small_matrix_arith_engine_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [smae_pkg::OP_W-1:0]          in_operation,
  input  logic [smae_pkg::IDX_W-1:0]         in_row_index,
  input  logic [smae_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [smae_pkg::DATA_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_status,
  output logic [smae_pkg::IDX_W-1:0]         out_row,
  output logic [smae_pkg::IDX_W-1:0]         out_col,
  output logic signed [smae_pkg::DATA_W-1:0] out_value,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smae_pkg::DIM_W-1:0]         cfg_data
);

  smae_pkg::dims_t             dims_r;
  logic                        ld_ok, we_a, we_b;
  logic [smae_pkg::ADDR_W-1:0] waddr, addr_a, addr_b;
  logic [smae_pkg::CELLS-1:0]  a_vld_r, b_vld_r;
  logic                        a_hit_r, b_hit_r;
  logic [smae_pkg::DATA_W-1:0] a_rdata, b_rdata, a_opnd, b_opnd, acc, value;
  smae_pkg::alu_ctl_t          alu_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows_a <= smae_pkg::DIM_W'(1);
      dims_r.cols_a <= smae_pkg::DIM_W'(1);
      dims_r.rows_b <= smae_pkg::DIM_W'(1);
      dims_r.cols_b <= smae_pkg::DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        smae_pkg::REG_ROWS_A: dims_r.rows_a <= cfg_data;
        smae_pkg::REG_COLS_A: dims_r.cols_a <= cfg_data;
        smae_pkg::REG_ROWS_B: dims_r.rows_b <= cfg_data;
        smae_pkg::REG_COLS_B: dims_r.cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ld_ok = ({1'b0, in_row_index} < smae_pkg::DIM_W'(smae_pkg::MAX_DIM)) &&
            ({1'b0, in_col_index} < smae_pkg::DIM_W'(smae_pkg::MAX_DIM));
    we_a  = in_valid && in_ready && ld_ok && (in_operation == smae_pkg::OP_LOAD_A);
    we_b  = in_valid && in_ready && ld_ok && (in_operation == smae_pkg::OP_LOAD_B);
    waddr = smae_pkg::cell_addr(in_row_index, in_col_index);
  end

  // valid bits stand in for the all-zero reset of the stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= '0;
      b_vld_r <= '0;
    end else begin
      if (we_a) a_vld_r[waddr] <= 1'b1;
      if (we_b) b_vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_r <= a_vld_r[addr_a];
    b_hit_r <= b_vld_r[addr_b];
  end

  smae_ram #(
    .WIDTH(smae_pkg::DATA_W),
    .DEPTH(smae_pkg::CELLS)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(in_element_value),
    .raddr(addr_a),
    .rdata(a_rdata)
  );

  smae_ram #(
    .WIDTH(smae_pkg::DATA_W),
    .DEPTH(smae_pkg::CELLS)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(in_element_value),
    .raddr(addr_b),
    .rdata(b_rdata)
  );

  assign a_opnd = a_hit_r ? a_rdata : '0;
  assign b_opnd = b_hit_r ? b_rdata : '0;

  smae_alu u_alu (
    .clk(clk),
    .ctl(alu_ctl),
    .a  (a_opnd),
    .b  (b_opnd),
    .acc(acc)
  );

  smae_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .dims        (dims_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_value   (value),
    .out_last    (out_last),
    .alu_ctl     (alu_ctl),
    .acc         (acc),
    .addr_a      (addr_a),
    .addr_b      (addr_b)
  );

  assign out_value = value;

  a_mism_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> out_last)
    else $error("mismatch word not marked last");

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_operation == smae_pkg::OP_LOAD_A || in_operation == smae_pkg::OP_LOAD_B))
    |=> in_ready)
    else $error("load word left the engine busy");

  a_op_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready &&
     (in_operation == smae_pkg::OP_ADD || in_operation == smae_pkg::OP_SUB ||
      in_operation == smae_pkg::OP_MUL || in_operation == smae_pkg::OP_TRANSPOSE))
    |=> !in_ready)
    else $error("arithmetic word accepted without going busy");

endmodule
